// File: rtl/ktrp_pkg.sv
// Package: shared types, codes and controller/datapath structs for the keyed table
`timescale 1ns / 1ps

package ktrp_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    FN_PUT    = 2'd0,
    FN_GET    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_PICK   = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_LOOK,
    S_TEST,
    S_MOVE,
    S_DONE
  } state_t;

  // Read address source
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LAST,
    RD_PICK
  } rd_sel_t;

  // Write kinds
  typedef enum logic [1:0] {
    WR_NONE,
    WR_HIT,
    WR_APPEND,
    WR_MOVE
  } wr_mode_t;

  // Source of the result data
  typedef enum logic [1:0] {
    DS_ZERO,
    DS_KEY,
    DS_VAL
  } data_sel_t;

  typedef logic signed [31:0] word32_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      take;
    logic      scan_clr;
    logic      scan_inc;
    logic      rd_en;
    rd_sel_t   rd_sel;
    wr_mode_t  wr_mode;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_set;
    logic      res_found;
    status_t   res_status;
    data_sel_t res_dsel;
    logic      out_load;
  } ktrp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic  in_valid;
    func_t func;
    logic  scan_end;
    logic  key_hit;
    logic  full;
    logic  empty;
    logic  pick_bad;
    logic  out_busy;
  } ktrp_sts_t;

endpackage

// File: rtl/ktrp_if.sv
// Interfaces: request and result channels of the keyed table
`timescale 1ns / 1ps

interface ktrp_in_if;
  logic                  valid;
  logic                  ready;
  ktrp_pkg::func_t       func;
  ktrp_pkg::word32_t     key;
  ktrp_pkg::word32_t     value;
  logic [3:0]            random_index;

  modport source (output valid, func, key, value, random_index, input ready);
  modport sink   (input valid, func, key, value, random_index, output ready);
endinterface

interface ktrp_out_if;
  logic                  valid;
  logic                  ready;
  ktrp_pkg::word32_t     data;
  logic                  found;
  ktrp_pkg::status_t     status;
  logic [4:0]            count;

  modport source (output valid, data, found, status, count, input ready);
  modport sink   (input valid, data, found, status, count, output ready);
endinterface

// File: rtl/keyed_table_random_pick_unit.sv
// Top level: keyed table with put, get, remove and pick by slot index
`timescale 1ns / 1ps

// Holds up to ENTRIES key/value pairs packed in slots 0..count-1, in two
// memories, each with one write and one registered read per cycle. A key
// is found by scanning the occupied slots in order; each slot compared is
// read in S_LOOK and tested in S_TEST. A put that misses appends its pair.
// A remove that hits also passes through S_MOVE, to move the last pair
// into the freed slot. A pick reads the slot at random_index directly,
// with no scan, unless the index is out of range. The single key-memory
// read port makes the scan compare one slot at a time. A finished result
// also waits in S_DONE while the output register still holds an earlier
// word that has not been taken. One word is worked on at a time; the next
// word is taken as soon as the result sits in the output register, even if
// it has not yet been taken. Pick reaches only slots 0..15 since random_index
// is 4 bits; count is reported in 5 bits. No clearing pass runs after reset.

module keyed_table_random_pick_unit #(
  parameter int ENTRIES = 16
) (
  input logic        clk,
  input logic        rst_n,
  ktrp_in_if.sink    in_bus,
  ktrp_out_if.source out_bus
);
  import ktrp_pkg::*;

  ktrp_cmd_t cmd;
  ktrp_sts_t sts;

  ktrp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ktrp_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Never append into a full table
  a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_mode == WR_APPEND) |-> !sts.full)
    else $error("append into full table");

  // Never shrink an empty table
  a_no_dec_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.empty)
    else $error("count decrement on empty table");

  // A result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result overwrites pending word");

  // In the cycle after a word is taken the unit does not take another
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("second word taken back to back");

endmodule

// File: rtl/ktrp_ctrl.sv
// Controller: sequences the slot scan, table updates and result hand-off
`timescale 1ns / 1ps

module ktrp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ktrp_pkg::ktrp_sts_t sts,
  output ktrp_pkg::ktrp_cmd_t cmd
);
  import ktrp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = (sts.func == FN_PICK) ? S_PICK : S_LOOK;
        end
      end
      S_PICK: state_nxt = S_DONE;
      S_LOOK: state_nxt = sts.scan_end ? S_DONE : S_TEST;
      S_TEST: begin
        if (!sts.key_hit) begin
          state_nxt = S_LOOK;
        end else if (sts.func == FN_REMOVE) begin
          state_nxt = S_MOVE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MOVE: state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.rd_sel     = RD_SCAN;
    cmd.wr_mode    = WR_NONE;
    cmd.res_status = ST_OK;
    cmd.res_dsel   = DS_ZERO;
    unique case (state_r)
      S_IDLE: begin
        cmd.take     = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_PICK: begin
        cmd.res_set = 1'b1;
        if (sts.pick_bad) begin
          cmd.res_status = ST_RANGE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_PICK;
          cmd.res_dsel = DS_KEY;
        end
      end
      S_LOOK: begin
        if (sts.scan_end) begin
          // key not present
          cmd.res_set = 1'b1;
          if (sts.func == FN_PUT) begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_mode = WR_APPEND;
              cmd.cnt_inc = 1'b1;
            end
          end else begin
            cmd.res_status = ST_ABSENT;
          end
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_TEST: begin
        if (sts.key_hit) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          unique case (sts.func)
            FN_PUT: cmd.wr_mode = WR_HIT;
            FN_GET: begin
              cmd.rd_en    = 1'b1;
              cmd.res_dsel = DS_VAL;
            end
            FN_REMOVE: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
            end
            FN_PICK: cmd.res_found = 1'b0;
            default: cmd.res_found = 1'b0;
          endcase
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.wr_mode = WR_MOVE;
        cmd.cnt_dec = 1'b1;
      end
      S_DONE: cmd.out_load = !sts.out_busy;
      default: cmd.take = 1'b0;
    endcase
  end

endmodule

// File: rtl/ktrp_dp.sv
// Datapath: key/value memories, scan index, entry count and result register
`timescale 1ns / 1ps

module ktrp_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  ktrp_in_if.sink             in_bus,
  ktrp_out_if.source          out_bus,
  input  ktrp_pkg::ktrp_cmd_t cmd,
  output ktrp_pkg::ktrp_sts_t sts
);
  import ktrp_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > 4) ? CW : 4;

  // Latched request word
  func_t      op_func_r;
  word32_t    op_key_r;
  word32_t    op_value_r;
  logic [3:0] op_idx_r;

  logic [CW-1:0] scan_r;
  logic [CW-1:0] count_r;

  // Table memories and registered read data
  word32_t key_mem [ENTRIES];
  word32_t val_mem [ENTRIES];
  word32_t key_q_r;
  word32_t val_q_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_key_en;
  logic          wr_val_en;
  word32_t       wr_key;
  word32_t       wr_val;

  // Result staging
  logic      res_found_r;
  status_t   res_status_r;
  data_sel_t res_dsel_r;

  logic      out_valid_r;
  word32_t   out_data_r;
  logic      out_found_r;
  status_t   out_status_r;
  logic [4:0] out_count_r;
  word32_t   res_data;

  assign in_bus.ready = cmd.take;

  // Request capture
  always_ff @(posedge clk) begin
    if (in_bus.valid && cmd.take) begin
      op_func_r  <= in_bus.func;
      op_key_r   <= in_bus.key;
      op_value_r <= in_bus.value;
      op_idx_r   <= in_bus.random_index;
    end
  end

  // Scan index and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + CW'(1);
    end
  end

  // Address and write data selection
  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN: rd_addr = AW'(scan_r);
      RD_LAST: rd_addr = AW'(count_r - CW'(1));
      RD_PICK: rd_addr = AW'(op_idx_r);
      default: rd_addr = AW'(scan_r);
    endcase
  end

  always_comb begin
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    wr_addr   = AW'(scan_r);
    wr_key    = op_key_r;
    wr_val    = op_value_r;
    unique case (cmd.wr_mode)
      WR_NONE: wr_val_en = 1'b0;
      WR_HIT:  wr_val_en = 1'b1;
      WR_APPEND: begin
        wr_key_en = 1'b1;
        wr_val_en = 1'b1;
        wr_addr   = AW'(count_r);
      end
      WR_MOVE: begin
        // last pair fills the hole
        wr_key_en = 1'b1;
        wr_val_en = 1'b1;
        wr_key    = key_q_r;
        wr_val    = val_q_r;
      end
      default: wr_val_en = 1'b0;
    endcase
  end

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (cmd.rd_en) begin
      key_q_r <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (cmd.rd_en) begin
      val_q_r <= val_mem[rd_addr];
    end
  end

  // Result fields decided by the controller
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_found_r  <= cmd.res_found;
      res_status_r <= cmd.res_status;
      res_dsel_r   <= cmd.res_dsel;
    end
  end

  always_comb begin
    unique case (res_dsel_r)
      DS_ZERO: res_data = '0;
      DS_KEY:  res_data = key_q_r;
      DS_VAL:  res_data = val_q_r;
      default: res_data = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= res_data;
      out_found_r  <= res_found_r;
      out_status_r <= res_status_r;
      out_count_r  <= 5'(count_r);
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.data   = out_data_r;
  assign out_bus.found  = out_found_r;
  assign out_bus.status = out_status_r;
  assign out_bus.count  = out_count_r;

  // Status to controller
  assign sts.in_valid = in_bus.valid;
  assign sts.func     = (cmd.take) ? in_bus.func : op_func_r;
  assign sts.scan_end = (scan_r >= count_r);
  assign sts.key_hit  = (key_q_r == op_key_r);
  assign sts.full     = (count_r == CW'(ENTRIES));
  assign sts.empty    = (count_r == '0);
  assign sts.pick_bad = (MW'(op_idx_r) >= MW'(count_r));
  assign sts.out_busy = out_valid_r && !out_bus.ready;

endmodule

// File: dv/tb_top.sv
// Testbench: keyed table put/get/remove/pick checked against an in-bench table predictor
`timescale 1ns / 1ps

module tb_top;
  import ktrp_pkg::*;

  localparam int SLOTS       = 16;
  localparam int POOL_SZ     = 24;
  localparam int RAND_WORDS  = 375;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 50;

  // One result word
  typedef struct packed {
    word32_t    data;
    logic       found;
    status_t    status;
    logic [4:0] count;
  } kv_res_t;

  // One request word, with an optional typed-in result
  typedef struct {
    func_t      op;
    word32_t    key;
    word32_t    value;
    logic [3:0] idx;
    bit         typed;
    kv_res_t    res;
  } kv_req_t;

  logic clk;
  logic rst_n;

  ktrp_in_if  in_bus ();
  ktrp_out_if out_bus ();

  keyed_table_random_pick_unit #(.ENTRIES(SLOTS)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Predictor state
  word32_t    slot_key [SLOTS];
  word32_t    slot_val [SLOTS];
  int         slot_cnt;

  kv_res_t    pending_results [$];
  kv_req_t    stim_rows [$];
  word32_t    key_pool [POOL_SZ];
  int         err_cnt;
  int         snd_idle;
  int         rcv_idle;
  int         idle_cycles;
  bit         fill_mode;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Associative lookup over the occupied slots; -1 on a miss
  function automatic int slot_of(input word32_t k);
    for (int i = 0; i < slot_cnt; i++) begin
      if (slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Apply one word to the predicted table and return its result
  function automatic kv_res_t kv_apply(input kv_req_t req);
    kv_res_t r;
    int      s;
    r = '{data: '0, found: 1'b0, status: ST_OK, count: '0};
    s = slot_of(req.key);
    case (req.op)
      FN_PUT: begin
        if (s >= 0) begin
          slot_val[s] = req.value;
          r.found = 1'b1;
        end else if (slot_cnt < SLOTS) begin
          slot_key[slot_cnt] = req.key;
          slot_val[slot_cnt] = req.value;
          slot_cnt++;
        end else begin
          r.status = ST_FULL;
        end
      end
      FN_GET: begin
        if (s >= 0) begin
          r.data  = slot_val[s];
          r.found = 1'b1;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      FN_REMOVE: begin
        if (s >= 0) begin
          // last pair fills the hole
          slot_key[s] = slot_key[slot_cnt - 1];
          slot_val[s] = slot_val[slot_cnt - 1];
          slot_cnt--;
          r.found = 1'b1;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        if (int'(req.idx) >= slot_cnt) r.status = ST_RANGE;
        else r.data = slot_key[req.idx];
      end
    endcase
    r.count = slot_cnt[4:0];
    return r;
  endfunction

  // Directed row; typed rows carry their own result
  task automatic add_row(input func_t op, input word32_t k, input word32_t v,
                         input logic [3:0] ix, input bit typed, input word32_t d,
                         input logic f, input status_t st, input logic [4:0] c);
    kv_req_t row;
    row.op    = op;
    row.key   = k;
    row.value = v;
    row.idx   = ix;
    row.typed = typed;
    row.res   = '{data: d, found: f, status: st, count: c};
    stim_rows = {stim_rows, row};
  endtask

  // Drive one word and record its expected result once it is taken
  task automatic send_word(input kv_req_t req);
    kv_res_t r;
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid        <= 1'b1;
    in_bus.func         <= req.op;
    in_bus.key          <= req.key;
    in_bus.value        <= req.value;
    in_bus.random_index <= req.idx;
    do @(posedge clk); while (!in_bus.ready);
    r = kv_apply(req);
    if (req.typed) r = req.res;
    pending_results = {pending_results, r};
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic word32_t pick_key(input int pct_present);
    if (slot_cnt > 0 && $urandom_range(99) < pct_present)
      return slot_key[$urandom_range(slot_cnt - 1)];
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SZ - 1)];
    return word32_t'($urandom);
  endfunction

  // Random word; swings between filling and draining the table
  function automatic kv_req_t rand_word();
    kv_req_t req;
    int      roll;
    if (slot_cnt == SLOTS) fill_mode = 1'b0;
    if (slot_cnt == 0) fill_mode = 1'b1;
    roll      = $urandom_range(99);
    req.typed = 1'b0;
    req.res   = '0;
    req.value = word32_t'($urandom);
    req.idx   = 4'($urandom_range(15));
    if (fill_mode) begin
      req.op = (roll < 50) ? FN_PUT : (roll < 70) ? FN_GET :
               (roll < 85) ? FN_REMOVE : FN_PICK;
    end else begin
      req.op = (roll < 15) ? FN_PUT : (roll < 35) ? FN_GET :
               (roll < 85) ? FN_REMOVE : FN_PICK;
    end
    req.key = pick_key((req.op == FN_PUT) ? 20 : 55);
    if (req.op == FN_PICK && slot_cnt > 0 && $urandom_range(99) < 30)
      req.idx = 4'($urandom_range(slot_cnt - 1));
    return req;
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Result checker and stall watchdog
  always @(posedge clk) begin
    kv_res_t exp_r;
    bit      in_take;
    bit      out_take;
    in_take  = in_bus.valid && in_bus.ready;
    out_take = out_bus.valid && out_bus.ready;
    if (rst_n && out_take) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: data %0d count %0d",
               out_bus.data, out_bus.count);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_bus.data !== exp_r.data) begin
          $error("data: expected %0d, got %0d", exp_r.data, out_bus.data);
          err_cnt++;
        end
        if (out_bus.found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_bus.found);
          err_cnt++;
        end
        if (out_bus.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_bus.status);
          err_cnt++;
        end
        if (out_bus.count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, out_bus.count);
          err_cnt++;
        end
      end
    end
    if (in_take || out_take) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus
  initial begin
    word32_t k;
    err_cnt             = 0;
    idle_cycles         = 0;
    slot_cnt            = 0;
    fill_mode           = 1'b1;
    snd_idle            = 0;
    rcv_idle            = 0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.func         = FN_PUT;
    in_bus.key          = '0;
    in_bus.value        = '0;
    in_bus.random_index = '0;
    out_bus.ready       = 1'b0;

    // Directed: empty table, extremes, update, pick range, full table, move on remove
    add_row(FN_PICK,   32'sh0,        32'sh0,        4'd0,  1, 0, 0, ST_RANGE,  5'd0);
    add_row(FN_GET,    32'sh0,        32'sh0,        4'd0,  1, 0, 0, ST_ABSENT, 5'd0);
    add_row(FN_REMOVE, -32'sd1,       32'sh0,        4'd0,  1, 0, 0, ST_ABSENT, 5'd0);
    add_row(FN_PUT,    32'sh80000000, 32'sh7FFFFFFF, 4'd0,  1, 0, 0, ST_OK,     5'd1);
    add_row(FN_PUT,    32'sh7FFFFFFF, 32'sh80000000, 4'd0,  1, 0, 0, ST_OK,     5'd2);
    add_row(FN_GET,    32'sh80000000, 32'sh0,        4'd15, 1, 32'sh7FFFFFFF, 1, ST_OK, 5'd2);
    add_row(FN_PUT,    32'sh80000000, -32'sd1,       4'd0,  1, 0, 1, ST_OK,     5'd2);
    add_row(FN_PICK,   32'sh0,        32'sh0,        4'd1,  1, 32'sh7FFFFFFF, 0, ST_OK, 5'd2);
    add_row(FN_PICK,   32'sh0,        32'sh0,        4'd2,  1, 0, 0, ST_RANGE,  5'd2);
    for (int i = 1; i <= 14; i++) begin
      k = word32_t'(i * 32'h1357_9BDF);
      add_row(FN_PUT, k, ~k, 4'd0, 0, 0, 0, ST_OK, 5'd0);
    end
    add_row(FN_PUT,    32'sh0,        32'sh1,        4'd0,  1, 0, 0, ST_FULL,   5'd16);
    add_row(FN_PICK,   32'sh0,        32'sh0,        4'd15, 0, 0, 0, ST_OK,     5'd0);
    add_row(FN_REMOVE, 32'sh80000000, 32'sh0,        4'd0,  1, 0, 1, ST_OK,     5'd15);
    add_row(FN_GET,    word32_t'(14 * 32'h1357_9BDF), 32'sh0, 4'd0, 0, 0, 0, ST_OK, 5'd0);

    // Reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle = 29;
          rcv_idle = 50;
        end
        1: begin
          snd_idle = 50;
          rcv_idle = 29;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      // fresh key pool per phase, extremes kept in front
      key_pool[0] = 32'sh80000000;
      key_pool[1] = 32'sh7FFFFFFF;
      key_pool[2] = 32'sh0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SZ; i++) key_pool[i] = word32_t'($urandom);

      if (phase == 0) begin
        foreach (stim_rows[i]) send_word(stim_rows[i]);
        drain_results();
      end
      for (int n = 0; n < RAND_WORDS; n++) send_word(rand_word());
      drain_results();
    end

    // Let the block settle, then report
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ktrp_pkg.sv
rtl/ktrp_if.sv
rtl/ktrp_ctrl.sv
rtl/ktrp_dp.sv
rtl/keyed_table_random_pick_unit.sv
dv/tb_top.sv
